### design/json_string_unescape_top_defines.svh
// assertion macros used by json_string_unescape_top
`ifndef JSON_STRING_UNESCAPE_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define JSU_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("jsu assertion failed");

// next-cycle implication, checked outside reset
`define JSU_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("jsu assertion failed");

`endif

### design/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;

  // characters with a special role
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_B         = 8'h62;
  localparam logic [7:0] CH_F         = 8'h66;
  localparam logic [7:0] CH_N         = 8'h6E;
  localparam logic [7:0] CH_R         = 8'h72;
  localparam logic [7:0] CH_T         = 8'h74;
  localparam logic [7:0] CH_U         = 8'h75;

  // control codes for the short escapes
  localparam logic [7:0] CC_BS = 8'h08;
  localparam logic [7:0] CC_FF = 8'h0C;
  localparam logic [7:0] CC_LF = 8'h0A;
  localparam logic [7:0] CC_CR = 8'h0D;
  localparam logic [7:0] CC_HT = 8'h09;

  // digits in a u escape
  localparam logic [2:0] HEX_DIGITS = 3'd4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       input_exhausted;
  } in_word_t;

  typedef struct packed {
    logic [7:0] byte_high;
    logic [7:0] byte_low;
    logic [1:0] byte_count;
    logic       string_end;
    logic [1:0] status;
  } out_word_t;

  // hex digit value in [3:0], bit 4 set when not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = {1'b0, 4'(b - 8'h37)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = {1'b0, 4'(b - 8'h57)};
    end
    return v;
  endfunction

endpackage

`default_nettype wire

### design/json_string_unescape_top.sv
`default_nettype none
// channel   | direction | payload      | handshake
// ----------+-----------+--------------+---------------------
// in        | input     | in_word_t    | in_valid / in_ready
// out       | output    | out_word_t   | out_valid / out_ready
//
// one word per cycle while in_ready is high: each word is decoded combinationally
// against the escape state; its result lands in the output or skid register
// a two-entry output (main register plus skid register) lets a new word in
// while a result waits; in_ready drops only when the skid register is full
// synchronous active-high reset clears the escape state and both valid bits
// words that yield no result (backslash, u, inner hex digits) only update state
module json_string_unescape_top (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire jsu_pkg::in_word_t in_word,
  output logic                  out_valid,
  input  wire                   out_ready,
  output jsu_pkg::out_word_t    out_word
);
  import jsu_pkg::*;

  `include "json_string_unescape_top_defines.svh"

  // escape state
  logic        escape_pending, escape_pending_next;
  logic [2:0]  hex_left, hex_left_next;
  logic [15:0] hex_acc, hex_acc_next;

  // skid register behind the output register
  logic        skid_valid;
  out_word_t   skid_word;

  // result of the word at the input
  logic        res_valid;
  out_word_t   res;
  logic [4:0]  hv;

  logic        in_acc;
  logic        push;
  logic        pop;

  assign in_ready = !skid_valid;
  assign in_acc   = in_valid && in_ready;
  assign push     = in_acc && res_valid;
  assign pop      = out_valid && out_ready;

  // decode one byte against the current escape state
  always_comb begin
    escape_pending_next = escape_pending;
    hex_left_next       = hex_left;
    hex_acc_next        = hex_acc;
    res_valid           = 1'b0;
    res                 = '0;
    hv                  = hex_value(in_word.in_byte);
    priority if (in_word.input_exhausted) begin
      // source ran dry, whatever the state
      escape_pending_next = 1'b0;
      hex_left_next       = '0;
      res_valid           = 1'b1;
      res.status          = ST_EXHAUSTED;
    end else if (hex_left != 3'd0) begin
      // inside a u escape
      if (hv[4]) begin
        hex_left_next = '0;
        res_valid     = 1'b1;
        res.status    = ST_INVALID;
      end else begin
        hex_acc_next  = {hex_acc[11:0], hv[3:0]};
        hex_left_next = hex_left - 3'd1;
        if (hex_left == 3'd1) begin
          // last digit: emit the code, high byte first
          res_valid      = 1'b1;
          res.byte_high  = hex_acc_next[15:8];
          res.byte_low   = hex_acc_next[7:0];
          res.byte_count = 2'd2;
          res.status     = ST_OK;
        end
      end
    end else if (escape_pending) begin
      // escape letter
      escape_pending_next = 1'b0;
      res_valid           = 1'b1;
      res.byte_count      = 2'd1;
      res.status          = ST_OK;
      unique case (in_word.in_byte)
        CH_QUOTE:     res.byte_low = CH_QUOTE;
        CH_BACKSLASH: res.byte_low = CH_BACKSLASH;
        CH_SLASH:     res.byte_low = CH_SLASH;
        CH_B:         res.byte_low = CC_BS;
        CH_F:         res.byte_low = CC_FF;
        CH_N:         res.byte_low = CC_LF;
        CH_R:         res.byte_low = CC_CR;
        CH_T:         res.byte_low = CC_HT;
        CH_U: begin
          // start collecting hex digits, no result yet
          res_valid      = 1'b0;
          res.byte_count = 2'd0;
          hex_left_next  = HEX_DIGITS;
          hex_acc_next   = '0;
        end
        default: begin
          res.byte_count = 2'd0;
          res.status     = ST_INVALID;
        end
      endcase
    end else if (in_word.in_byte == CH_QUOTE) begin
      // closing quote
      res_valid      = 1'b1;
      res.string_end = 1'b1;
      res.status     = ST_OK;
    end else if (in_word.in_byte == CH_BACKSLASH) begin
      escape_pending_next = 1'b1;
    end else begin
      // plain byte passes through
      res_valid      = 1'b1;
      res.byte_low   = in_word.in_byte;
      res.byte_count = 2'd1;
      res.status     = ST_OK;
    end
  end

  // escape state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      hex_left       <= '0;
    end else if (in_acc) begin
      escape_pending <= escape_pending_next;
      hex_left       <= hex_left_next;
    end
  end

  // accumulator is cleared on entry to a u escape
  always_ff @(posedge clk) begin
    if (rst) begin
      hex_acc <= '0;
    end else if (in_acc) begin
      hex_acc <= hex_acc_next;
    end
  end

  // output register and skid register valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      // output stalled: park the new result
      skid_valid <= 1'b1;
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= res;
      end else begin
        out_word  <= res;
      end
    end else if (push) begin
      skid_word <= res;
    end
  end

  // the skid register only fills behind a held output
  `JSU_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid)
  // a u escape never counts more than four digits
  `JSU_ASSERT_NOW(a_hex_left_range, 1'b1, hex_left <= HEX_DIGITS)
  // an escape letter and a hex digit are never awaited together
  `JSU_ASSERT_NOW(a_esc_hex_exclusive, hex_left != 3'd0, !escape_pending)
  // a full skid register blocks the input on the next cycle too unless drained
  `JSU_ASSERT_NEXT(a_skid_holds, skid_valid && !out_ready, skid_valid && !in_ready)

endmodule

`default_nettype wire
